[design/key_matrix_release_debounce_top_assert.svh]
// Assertion macros for the key matrix release debouncer.
`ifndef KEY_MATRIX_RELEASE_DEBOUNCE_TOP_ASSERT_SVH
`define KEY_MATRIX_RELEASE_DEBOUNCE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define KMRD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define KMRD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define KMRD_ASSERT(lbl, clk, rstn, prop)
`define KMRD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[design/kmrd_pkg.sv]
package kmrd_pkg;

    localparam int KEY_W    = 6;
    localparam int KEY_SPAN = 2 ** KEY_W;
    localparam int TIME_W   = 32;
    localparam int HOLD_W   = 20;
    localparam int CNT_W    = 7;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam int unsigned US_PER_MS = 1000;
    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(5 * US_PER_MS);

    typedef struct packed {
        logic              deb;
        logic              prev_level;
        logic              pend;
        logic [TIME_W-1:0] start;
    } key_entry_t;

    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        key_entry_t       entry;
    } mem_wr_t;

    typedef struct packed {
        key_entry_t entry;
        logic       pend_set;
        logic       pend_clr;
    } upd_t;

endpackage

[design/kmrd_state_mem.sv]
module kmrd_state_mem #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [kmrd_pkg::KEY_W-1:0]   rd_key,
    input  kmrd_pkg::mem_wr_t            wr,
    output kmrd_pkg::key_entry_t         rd_entry
);
    import kmrd_pkg::*;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    key_entry_t        mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    key_entry_t        rd_data_reg;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;

    assign raddr = rd_key[ADDR_W-1:0];
    assign waddr = wr.key[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[waddr] <= wr.entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[raddr];
            end
        end
    end

    // never-written entries read as cleared flags
    always_comb begin
        rd_entry            = rd_data_reg;
        rd_entry.deb        = rd_vld_reg & rd_data_reg.deb;
        rd_entry.prev_level = rd_vld_reg & rd_data_reg.prev_level;
        rd_entry.pend       = rd_vld_reg & rd_data_reg.pend;
    end

endmodule

[design/kmrd_update.sv]
module kmrd_update (
    input  kmrd_pkg::key_entry_t           cur,
    input  logic                           mode,
    input  logic                           raw,
    input  logic [kmrd_pkg::TIME_W-1:0]    now,
    input  logic [kmrd_pkg::HOLD_W-1:0]    hold,
    output kmrd_pkg::upd_t                 upd
);
    import kmrd_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic              expired;
    key_entry_t        nxt;

    assign elapsed = now - cur.start;
    assign expired = elapsed >= TIME_W'(hold);

    always_comb begin
        nxt = cur;
        if (mode == MODE_CLEAR) begin
            nxt.deb        = 1'b0;
            nxt.prev_level = 1'b0;
            nxt.pend       = 1'b0;
        end else begin
            if (raw != cur.prev_level) begin
                if (raw) begin
                    nxt.deb  = 1'b1;
                    nxt.pend = 1'b0;
                end else begin
                    nxt.start = now;
                    nxt.pend  = 1'b1;
                end
            end else if (!raw && cur.deb && cur.pend && expired) begin
                nxt.deb  = 1'b0;
                nxt.pend = 1'b0;
            end
            nxt.prev_level = raw;
        end
        upd.entry    = nxt;
        upd.pend_set = nxt.pend & ~cur.pend;
        upd.pend_clr = cur.pend & ~nxt.pend;
    end

endmodule

[design/key_matrix_release_debounce_top.sv]
// channel | direction | handshake            | payload
// s_      | in        | s_valid / s_ready    | mode, key_sel, raw_pressed, now_us
// m_      | out       | m_valid / m_ready    | key_out, debounced_pressed,
//         |           |                      | release_pending, pending_count
// cfg_    | in        | cfg_valid / cfg_ready| release_hold_us
// One request per cycle unless stalled; requests sit in s1, results in m_.
// Per-key state sits in one memory with a registered read; a write to the same
// key, made as the following request is accepted, is forwarded to that request.
// Reset is synchronous; per-key valid bits clear at once, so no clearing pass.
// A stalled result holds the update stage; input stalls only then.
module key_matrix_release_debounce_top #(
    parameter int NUM_KEYS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_mode,
    input  logic [kmrd_pkg::KEY_W-1:0]     s_key_sel,
    input  logic                           s_raw_pressed,
    input  logic [kmrd_pkg::TIME_W-1:0]    s_now_us,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [kmrd_pkg::KEY_W-1:0]     m_key_out,
    output logic                           m_debounced_pressed,
    output logic                           m_release_pending,
    output logic [kmrd_pkg::CNT_W-1:0]     m_pending_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kmrd_pkg::HOLD_W-1:0]    cfg_release_hold_us
);
    import kmrd_pkg::*;

    localparam int DEPTH = (NUM_KEYS < KEY_SPAN) ? NUM_KEYS : KEY_SPAN;

    logic [HOLD_W-1:0] hold_reg;
    logic              s1_vld_reg;
    logic              s1_mode_reg;
    logic [KEY_W-1:0]  s1_key_reg;
    logic              s1_raw_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              fwd_hit_reg;
    key_entry_t        fwd_entry_reg;
    logic [CNT_W-1:0]  pend_total_reg;
    logic [CNT_W-1:0]  pend_total_next;
    logic              m_valid_reg;
    logic [KEY_W-1:0]  m_key_reg;
    logic              m_deb_reg;
    logic              m_pend_reg;
    logic [CNT_W-1:0]  m_cnt_reg;

    logic              s_acc;
    logic              s1_adv;
    logic              in_range;
    key_entry_t        mem_entry;
    key_entry_t        cur_entry;
    upd_t              upd;
    mem_wr_t           wr;

    assign cfg_ready = 1'b1;
    assign s1_adv    = s1_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_vld_reg || s1_adv;
    assign s_acc     = s_valid && s_ready;
    assign in_range  = 9'(s1_key_reg) < 9'(NUM_KEYS);

    assign wr.en    = s1_adv && in_range;
    assign wr.key   = s1_key_reg;
    assign wr.entry = upd.entry;

    assign cur_entry = fwd_hit_reg ? fwd_entry_reg : mem_entry;

    always_comb begin
        pend_total_next = pend_total_reg;
        if (wr.en) begin
            pend_total_next = pend_total_reg + CNT_W'(upd.pend_set) - CNT_W'(upd.pend_clr);
        end
    end

    kmrd_state_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_acc),
        .rd_key   (s_key_sel),
        .wr       (wr),
        .rd_entry (mem_entry)
    );

    kmrd_update u_upd (
        .cur  (cur_entry),
        .mode (s1_mode_reg),
        .raw  (s1_raw_reg),
        .now  (s1_now_reg),
        .hold (hold_reg),
        .upd  (upd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg       <= HOLD_RESET;
            s1_vld_reg     <= 1'b0;
            pend_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hold_reg <= cfg_release_hold_us;
            end
            if (s_ready) begin
                s1_vld_reg <= s_valid;
            end
            pend_total_reg <= pend_total_next;
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_mode_reg   <= s_mode;
            s1_key_reg    <= s_key_sel;
            s1_raw_reg    <= s_raw_pressed;
            s1_now_reg    <= s_now_us;
            // forward the entry written at this edge to the next request
            fwd_hit_reg   <= wr.en && (s1_key_reg == s_key_sel);
            fwd_entry_reg <= upd.entry;
        end
        if (s1_adv) begin
            m_key_reg  <= s1_key_reg;
            m_deb_reg  <= in_range & upd.entry.deb;
            m_pend_reg <= in_range & upd.entry.pend;
            m_cnt_reg  <= pend_total_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_key_out           = m_key_reg;
    assign m_debounced_pressed = m_deb_reg;
    assign m_release_pending   = m_pend_reg;
    assign m_pending_count     = m_cnt_reg;

`include "key_matrix_release_debounce_top_assert.svh"

    `KMRD_ASSERT(a_count_bound, aclk, aresetn, pend_total_reg <= CNT_W'(DEPTH))
    `KMRD_ASSERT(a_no_write_on_stall, aclk, aresetn, (m_valid_reg && !m_ready) |-> !wr.en)
    `KMRD_ASSERT(a_stall_needs_item, aclk, aresetn, !s_ready |-> s1_vld_reg)
    `KMRD_ASSERT(a_count_moves_on_write, aclk, aresetn, !wr.en |=> $stable(pend_total_reg))
    `KMRD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (pend_total_reg == '0 && !m_valid_reg))

endmodule
